[design/ppm_pkg.sv]
// Shared types, constants and helpers for the PCM peak level meter.
// No dependencies; every other file of the block imports this package.
package ppm_pkg;

  // Payload widths
  localparam int ByteW    = 8;
  localparam int SampleW  = 16;
  localparam int LevelW   = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 1;

  // Divider widths: numerator 200*peak+full, denominator 2*full
  localparam int NumW  = 24;
  localparam int DenW  = SampleW + 1;
  localparam int StepW = 3;

  // Full-scale amplitudes
  localparam logic [SampleW-1:0] FullU8  = 16'd255;
  localparam logic [SampleW-1:0] FullS8  = 16'd127;
  localparam logic [SampleW-1:0] FullU16 = 16'd65535;
  localparam logic [SampleW-1:0] FullS16 = 16'd32767;

  localparam logic [LevelW-1:0] LevelMax = 7'd100;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_METER_ENABLE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDE_SAMPLES     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SIGNED_SAMPLES   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_BIG_ENDIAN_ORDER = 2'd3;

  // Sample format as seen by the sample path
  typedef struct packed {
    logic wide;
    logic sgn;
    logic big;
  } fmt_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } seq_state_t;

  function automatic logic [SampleW-1:0] full_scale(input logic wide, input logic sgn);
    logic [SampleW-1:0] f;
    if (wide) begin
      f = sgn ? FullS16 : FullU16;
    end else begin
      f = sgn ? FullS8 : FullU8;
    end
    return f;
  endfunction

endpackage

[design/ppm_if.sv]
// Handshake channels of the PCM peak level meter: byte input and result output.
// Depends on ppm_pkg for payload widths.
interface ppm_in_if import ppm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   data_byte;
  logic               end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LevelW-1:0]   level_percent;
  logic [SampleW-1:0]  peak_magnitude;

  modport source (output valid, output level_percent, output peak_magnitude, input ready);
  modport sink (input valid, input level_percent, input peak_magnitude, output ready);
endinterface

[design/ppm_sample_unit.sv]
// Sample assembly, magnitude, saturation and running peak of one buffer.
// Depends on ppm_pkg (fmt_t, full_scale).
module ppm_sample_unit import ppm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [ByteW-1:0]   data_byte,
  input  logic               last,
  input  fmt_t               fmt,
  output logic [SampleW-1:0] final_peak,
  output logic [SampleW-1:0] full
);

  logic [ByteW-1:0]   held_r, held_nxt;
  logic               phase_r, phase_nxt;
  logic [SampleW-1:0] peak_r, peak_nxt;

  logic [SampleW-1:0] raw;
  logic               have;
  logic               neg;
  logic [SampleW:0]   modulus;
  logic [SampleW:0]   mag;
  logic [SampleW-1:0] sat;
  logic [SampleW-1:0] peak_upd;

  assign full = full_scale(fmt.wide, fmt.sgn);

  // Assemble a sample from one or two bytes
  always_comb begin
    raw       = '0;
    have      = 1'b0;
    held_nxt  = held_r;
    phase_nxt = 1'b0;
    if (!fmt.wide) begin
      raw  = {{(SampleW-ByteW){1'b0}}, data_byte};
      have = 1'b1;
    end else if (!phase_r) begin
      held_nxt  = data_byte;
      phase_nxt = 1'b1;
    end else begin
      raw  = fmt.big ? {held_r, data_byte} : {data_byte, held_r};
      have = 1'b1;
    end
  end

  // Take magnitude, saturate to full scale, update the peak
  always_comb begin
    neg      = fmt.sgn & (fmt.wide ? raw[SampleW-1] : raw[ByteW-1]);
    modulus  = fmt.wide ? (17'd1 << SampleW) : (17'd1 << ByteW);
    mag      = neg ? (modulus - {1'b0, raw}) : {1'b0, raw};
    sat      = (mag > {1'b0, full}) ? full : mag[SampleW-1:0];
    peak_upd = (have && (sat > peak_r)) ? sat : peak_r;
    final_peak = (peak_upd > full) ? full : peak_upd;
    peak_nxt = last ? '0 : peak_upd;
  end

  // Hold state; clear it at the buffer end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      phase_r <= 1'b0;
      peak_r  <= '0;
    end else if (take) begin
      held_r  <= last ? '0 : held_nxt;
      phase_r <= last ? 1'b0 : phase_nxt;
      peak_r  <= peak_nxt;
    end
  end

endmodule

[design/ppm_div_unit.sv]
// Iterative restoring divider for the level: (200*peak + full) / (2*full).
// One quotient bit per cycle, seven quotient bits in all. Depends on ppm_pkg.
module ppm_div_unit import ppm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SampleW-1:0] peak,
  input  logic [SampleW-1:0] full,
  output div_status_t        status,
  output logic [LevelW-1:0]  quotient
);

  logic [NumW-1:0]   rem_r, rem_nxt;
  logic [NumW-1:0]   den_r, den_nxt;
  logic [LevelW-1:0] quo_r, quo_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [NumW-1:0] num;
  logic [NumW-1:0] peak_x;
  logic            fits;

  // Form 200*peak + full with shifts and adds
  assign peak_x = {{(NumW-SampleW){1'b0}}, peak};
  assign num    = (peak_x << 7) + (peak_x << 6) + (peak_x << 3)
                + {{(NumW-SampleW){1'b0}}, full};

  assign fits = (rem_r >= den_r);

  // Step the shared compare and subtract
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = {{(NumW-DenW){1'b0}}, full, 1'b0} << (LevelW - 1);
      quo_nxt  = '0;
      step_nxt = StepW'(LevelW - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_r - den_r) : rem_r;
      den_nxt = den_r >> 1;
      quo_nxt = {quo_r[LevelW-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

  // Checks
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r)) else $error("divider busy and done together");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && step_r == '0) |=> done_r) else $error("divider did not finish");

endmodule

[design/pcm_peak_level_meter_core.sv]
// PCM peak level meter top level: configuration registers, sequencer, output register.
// Depends on ppm_pkg, ppm_if, ppm_sample_unit and ppm_div_unit.
//
// Usage: bytes of an interleaved PCM buffer enter on in_bus, one per accepted item,
// with end_of_buffer set on the final byte. Samples are 8 or 16 bits, signed or
// unsigned, little or big endian, as set over the cfg_ write port (write only while
// idle). At each buffer end with meter_enable set, one result item leaves on out_bus:
// the saturated peak and the level in percent rounded half up.
// Bytes that are not the last of a buffer are taken back to back. A last byte
// with the meter enabled starts the shared restoring divider, which makes one
// quotient bit per cycle; in_bus is not ready during its 7 divide steps and until
// the output register is loaded, so each enabled buffer end stalls the input.
// The result sits in an output register; while out_bus stalls, input bytes are still
// taken, and only a following buffer end waits for the register to drain.
// Reset (synchronous, rst_n low) clears the peak, the byte phase, the sequencer and
// the output valid, and restores the format to 16-bit signed little endian, disabled.
module pcm_peak_level_meter_core import ppm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  ppm_in_if.sink              in_bus,
  ppm_out_if.source           out_bus,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic enable_r;
  logic wide_r;
  logic sgn_r;
  logic big_r;

  seq_state_t state_r, state_nxt;

  logic [SampleW-1:0] final_peak;
  logic [SampleW-1:0] full;
  logic [SampleW-1:0] peak_hold_r;
  logic [LevelW-1:0]  quotient;
  div_status_t        div_status;
  fmt_t               fmt;

  logic               out_valid_r;
  logic [LevelW-1:0]  out_level_r;
  logic [SampleW-1:0] out_peak_r;

  logic take;
  logic start;
  logic slot_free;
  logic load_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      wide_r   <= 1'b1;
      sgn_r    <= 1'b1;
      big_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METER_ENABLE:     enable_r <= cfg_data[0];
        CFG_WIDE_SAMPLES:     wide_r   <= cfg_data[0];
        CFG_SIGNED_SAMPLES:   sgn_r    <= cfg_data[0];
        CFG_BIG_ENDIAN_ORDER: big_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign fmt = '{wide: wide_r, sgn: sgn_r, big: big_r};

  assign in_bus.ready = (state_r == ST_IDLE);
  assign take      = in_bus.valid && in_bus.ready;
  assign start     = take && in_bus.end_of_buffer && enable_r;
  assign slot_free = !out_valid_r || out_bus.ready;
  assign load_out  = (state_r == ST_DIV) && div_status.done && slot_free;

  ppm_sample_unit u_sample (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_bus.data_byte),
    .last       (in_bus.end_of_buffer),
    .fmt        (fmt),
    .final_peak (final_peak),
    .full       (full)
  );

  ppm_div_unit u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .peak     (final_peak),
    .full     (full),
    .status   (div_status),
    .quotient (quotient)
  );

  // Sequencer: idle takes bytes, divide waits for the quotient and a free slot
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_DIV;
      ST_DIV:  if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the peak for the result
  always_ff @(posedge clk) begin
    if (start) begin
      peak_hold_r <= final_peak;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level_r <= quotient;
      out_peak_r  <= peak_hold_r;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.level_percent  = out_level_r;
  assign out_bus.peak_magnitude = out_peak_r;

  // Checks
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (quotient <= LevelMax)) else $error("level above full scale");
  a_start_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == ST_DIV && div_status.busy)) else $error("buffer end not divided");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.busy |-> (state_r == ST_DIV)) else $error("divider runs outside divide");

endmodule
